### src/lidfr_pkg.sv
// Shared types and constants for the lidar serial frame receiver.
package lidfr_pkg;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_BODY  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [15:0] temperature_raw;
    logic [15:0] strength;
    logic [15:0] distance;
    logic        checksum_ok;
  } frame_res_t;

  localparam logic [7:0] HEADER_RESET = 8'h59;
  localparam logic       REG_HEADER   = 1'b0;

  // byte positions of the payload fields within a frame
  localparam logic [3:0] POS_DIST_LO = 4'd2;
  localparam logic [3:0] POS_DIST_HI = 4'd3;
  localparam logic [3:0] POS_STR_LO  = 4'd4;
  localparam logic [3:0] POS_STR_HI  = 4'd5;
  localparam logic [3:0] POS_TMP_LO  = 4'd6;
  localparam logic [3:0] POS_TMP_HI  = 4'd7;

endpackage

### src/lidfr_core.sv
// Frame parser: header hunt, field assembly and checksum for one byte a cycle.
module lidfr_core #(
  parameter int FRAME_BYTES = 9
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   byte_valid,
  input  logic [7:0]             byte_i,
  input  logic [7:0]             header_i,
  output logic                   res_valid,
  output lidfr_pkg::frame_res_t  res
);
  import lidfr_pkg::*;

  localparam logic [3:0] LAST_IDX = 4'(FRAME_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [15:0] str_r, str_nxt;
  logic [15:0] tmp_r, tmp_nxt;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sum_nxt   = sum_r;
    dist_nxt  = dist_r;
    str_nxt   = str_r;
    tmp_nxt   = tmp_r;
    res_valid = 1'b0;
    res.distance        = dist_r;
    res.strength        = str_r;
    res.temperature_raw = tmp_r;
    res.checksum_ok     = (sum_r == byte_i);
    if (byte_valid) begin
      unique case (phase_r)
        PH_HUNT2: begin
          if (byte_i == header_i) begin
            sum_nxt   = sum_r + byte_i;
            idx_nxt   = POS_DIST_LO;
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT1;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end
        end
        PH_BODY: begin
          if (idx_r >= LAST_IDX) begin
            res_valid = 1'b1;
            phase_nxt = PH_HUNT1;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end else begin
            case (idx_r)
              POS_DIST_LO: dist_nxt[7:0]  = byte_i;
              POS_DIST_HI: dist_nxt[15:8] = byte_i;
              POS_STR_LO:  str_nxt[7:0]   = byte_i;
              POS_STR_HI:  str_nxt[15:8]  = byte_i;
              POS_TMP_LO:  tmp_nxt[7:0]   = byte_i;
              POS_TMP_HI:  tmp_nxt[15:8]  = byte_i;
              default: ;
            endcase
            sum_nxt = sum_r + byte_i;
            idx_nxt = idx_r + 4'd1;
          end
        end
        default: begin
          // first header byte; also recovers from any stray code
          if (byte_i == header_i) begin
            sum_nxt   = byte_i;
            idx_nxt   = 4'd1;
            phase_nxt = PH_HUNT2;
          end else begin
            phase_nxt = PH_HUNT1;
            idx_nxt   = '0;
            sum_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      idx_r   <= '0;
      sum_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    str_r  <= str_nxt;
    tmp_r  <= tmp_nxt;
  end

`ifndef SYNTHESIS
  a_hunt1_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT1 |-> idx_r == 4'd0 && sum_r == 8'd0)
    else $error("hunt state with stale index or sum");
  a_hunt2_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HUNT2 |-> idx_r == 4'd1)
    else $error("second header hunt with wrong index");
  a_body_idx: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> idx_r >= POS_DIST_LO && idx_r <= LAST_IDX)
    else $error("body index out of frame");
  a_res_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == PH_HUNT1)
    else $error("frame end did not return to hunting");
`endif

endmodule

### src/lidar_data_frame_receiver_top.sv
// Top level of the lidar serial frame receiver: config port and output register.
//
// Usage:
//   in_*  : one received serial byte per word (in_tdata[7:0]).
//   out_* : one word per complete frame. out_tdata carries distance [15:0],
//           strength [31:16] and temperature_raw [47:32]; out_tuser is the
//           checksum flag (1 = sum of all bytes before the last matches it).
//   cfg_* : APB-style port, register 0 at address 0 is the header byte value.
// Each byte is parsed in the cycle it is accepted; a frame's result is in the
// output register in the cycle after its last byte is taken. One byte can be
// accepted every cycle while in_tready is high; the parser state update is the only loop.
// in_tready drops only while a result waits in the output register and
// out_tready is low; a stalled result holds until taken.
// Reset (rst_n low, synchronous) returns the parser to hunting the first
// header byte, empties the output register and sets the header value to 0x59.
module lidar_data_frame_receiver_top #(
  parameter int FRAME_BYTES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] distance, [31:16] strength, [47:32] temperature_raw
  output logic        out_tuser,  // [0] checksum_ok
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lidfr_pkg::*;

  logic [7:0] header_val_r;
  logic       in_acc;
  logic       res_valid;
  frame_res_t res;
  logic       out_valid_r;
  frame_res_t out_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEADER) ? {24'd0, header_val_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_val_r <= HEADER_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && cfg_paddr[2] == REG_HEADER) begin
      header_val_r <= cfg_pwdata[7:0];
    end
  end

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  lidfr_core #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_acc),
    .byte_i     (in_tdata),
    .header_i   (header_val_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.temperature_raw, out_r.strength, out_r.distance};
  assign out_tuser  = out_r.checksum_ok;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_acc)
    else $error("byte accepted while result stalled");
  a_res_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid |=> out_valid_r)
    else $error("frame result lost");
  a_hdr_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_HEADER
    |=> header_val_r == $past(cfg_pwdata[7:0]))
    else $error("header register not written");
`endif

endmodule
